>>> src/sopl_pkg.sv
// Shared types, constants and saturation helper for the complex-pole lag filter.
package sopl_pkg;

    // Fixed widths of the sample path and of the shared multiplier.
    localparam int DATA_W    = 32;
    localparam int STATE_W   = 32;
    localparam int COEF_FRAC = 30;
    localparam int GAIN_FRAC = 16;
    localparam int OPND_W    = STATE_W + 1;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int ACC_W     = PROD_W + 1;

    // Register file layout: one 32-bit register per word.
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_C1_REAL    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_C1_IMAG    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_C2_REAL    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_C2_IMAG    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GAIN       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INIT_LEVEL = 3'd5;

    localparam logic signed [DATA_W-1:0] GAIN_RESET = 32'sh0001_0000;

    // Sequencer states: one per step of the shared multiply-accumulate.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_M6,
        ST_M7,
        ST_M8,
        ST_GAIN,
        ST_OUT
    } seq_state_t;

    // Operand pair fed to the shared multiplier.
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_C1R_DR,
        MUL_C1I_DI,
        MUL_C1R_DI,
        MUL_C1I_DR,
        MUL_C2R_ER,
        MUL_C2I_EI,
        MUL_GAIN_LVL
    } mul_sel_t;

    // Accumulator operation on the registered product.
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    // Control word from the sequencer to the datapath.
    typedef struct packed {
        logic     start_step;
        logic     start_restart;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     wr_inner_real;
        logic     wr_inner_imag;
        logic     wr_level;
        logic     out_load;
    } dp_ctrl_t;

    // Current register contents as seen by the datapath.
    typedef struct packed {
        logic signed [DATA_W-1:0] c1_real;
        logic signed [DATA_W-1:0] c1_imag;
        logic signed [DATA_W-1:0] c2_real;
        logic signed [DATA_W-1:0] c2_imag;
        logic signed [DATA_W-1:0] gain;
        logic signed [DATA_W-1:0] init_level;
    } coef_set_t;

    typedef struct packed {
        logic                      clip;
        logic signed [STATE_W-1:0] value;
    } sat_t;

    // Clamp a wide signed value to the state width and flag clipping.
    function automatic sat_t sat_word(input logic signed [ACC_W-1:0] v);
        sat_t r;
        logic fits;
        fits = (&v[ACC_W-1:STATE_W-1]) || !(|v[ACC_W-1:STATE_W-1]);
        if (fits)
        begin
            r.clip  = 1'b0;
            r.value = v[STATE_W-1:0];
        end
        else
        begin
            r.clip  = 1'b1;
            r.value = v[ACC_W-1] ? {1'b1, {(STATE_W-1){1'b0}}}
                                 : {1'b0, {(STATE_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

>>> src/second_order_complex_pole_lag_top.sv
// Top level of the second-order complex-pole lag filter.
// Each request carries op and a Q16.16 sample. An advance request updates the
// complex inner value and the real level through one shared 33x33 multiplier
// with an accumulator, then multiplies the level by the gain, busy through
// the eleven sequencer steps M0 to M8, GAIN and OUT; the next request is
// taken only in the idle state. A restart request loads the restart level
// and goes straight to the gain step. The result waits in an output
// register, so the next request is accepted while it is still stalled; a
// new result is only written once the previous one has been taken, and the
// sequencer holds in its output step until then. Registers are to be written
// over the APB port between requests; the block itself does not enforce it.
module second_order_complex_pole_lag_top
    import sopl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     op,
    input  logic signed [DATA_W-1:0] sample_in,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] sample_out,
    output logic                     saturated
);

    coef_set_t  coef;
    dp_ctrl_t   ctrl;
    seq_state_t seq_state;

    // Configuration registers.
    sopl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    // Step sequencer.
    sopl_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .op        (op),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .ctrl      (ctrl),
        .state     (seq_state)
    );

    // Shared arithmetic and filter state.
    sopl_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .coef       (coef),
        .sample_in  (sample_in),
        .sample_out (sample_out),
        .saturated  (saturated)
    );

`ifndef NO_ASSERTIONS
    // A restart request goes straight to the gain multiply.
    a_restart_path: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && op) |=> (seq_state == ST_GAIN))
        else $error("restart request did not go to the gain step");

    // An advance request starts the first coefficient multiply.
    a_step_path: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !op) |=> (seq_state == ST_M0))
        else $error("advance request did not start the multiply sequence");

    // A finished result is held back while the previous one is stalled.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_state == ST_OUT && out_valid && out_stall) |=> (seq_state == ST_OUT))
        else $error("result left the output step while the output was stalled");

    // The gain step always leads to the output step.
    a_gain_out: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_state == ST_GAIN) |=> (seq_state == ST_OUT))
        else $error("gain step not followed by output step");
`endif

endmodule

>>> src/sopl_regs.sv
// APB register file holding the filter coefficients, gain and restart level.
module sopl_regs
    import sopl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output coef_set_t         coef
);

    coef_set_t            coef_reg;
    coef_set_t            coef_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign coef    = coef_reg;

    // Write decode; addresses past the last register are ignored.
    always_comb
    begin
        coef_next = coef_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_C1_REAL:    coef_next.c1_real    = pwdata;
                REG_C1_IMAG:    coef_next.c1_imag    = pwdata;
                REG_C2_REAL:    coef_next.c2_real    = pwdata;
                REG_C2_IMAG:    coef_next.c2_imag    = pwdata;
                REG_GAIN:       coef_next.gain       = pwdata;
                REG_INIT_LEVEL: coef_next.init_level = pwdata;
                default:        coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.c1_real    <= '0;
            coef_reg.c1_imag    <= '0;
            coef_reg.c2_real    <= '0;
            coef_reg.c2_imag    <= '0;
            coef_reg.gain       <= GAIN_RESET;
            coef_reg.init_level <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    // Read mux.
    always_comb
    begin
        unique case (reg_idx)
            REG_C1_REAL:    prdata = coef_reg.c1_real;
            REG_C1_IMAG:    prdata = coef_reg.c1_imag;
            REG_C2_REAL:    prdata = coef_reg.c2_real;
            REG_C2_IMAG:    prdata = coef_reg.c2_imag;
            REG_GAIN:       prdata = coef_reg.gain;
            REG_INIT_LEVEL: prdata = coef_reg.init_level;
            default:        prdata = '0;
        endcase
    end

endmodule

>>> src/sopl_mac.sv
// Datapath: filter state, the shared multiplier, accumulator and saturation.
module sopl_mac
    import sopl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_ctrl_t                 ctrl,
    input  coef_set_t                coef,
    input  logic signed [DATA_W-1:0] sample_in,
    output logic signed [DATA_W-1:0] sample_out,
    output logic                     saturated
);

    logic signed [STATE_W-1:0] inner_real_reg;
    logic signed [STATE_W-1:0] inner_real_next;
    logic signed [STATE_W-1:0] inner_imag_reg;
    logic signed [STATE_W-1:0] inner_imag_next;
    logic signed [STATE_W-1:0] level_reg;
    logic signed [STATE_W-1:0] level_next;
    logic signed [OPND_W-1:0]  dr_reg;
    logic signed [OPND_W-1:0]  dr_next;
    logic signed [OPND_W-1:0]  di_reg;
    logic signed [OPND_W-1:0]  di_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic                      clip_reg;
    logic                      clip_next;
    logic signed [DATA_W-1:0]  sample_out_reg;
    logic                      saturated_reg;

    logic signed [OPND_W-1:0]  er;
    logic signed [OPND_W-1:0]  op_a;
    logic signed [OPND_W-1:0]  op_b;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [STATE_W-1:0] upd_state;
    logic signed [ACC_W-1:0]   upd_sum;
    logic signed [ACC_W-1:0]   out_shifted;
    sat_t                      upd_sat;
    sat_t                      out_sat;

    assign sample_out = sample_out_reg;
    assign saturated  = saturated_reg;

    // Level error uses the freshly updated real inner value.
    assign er = {inner_real_reg[STATE_W-1], inner_real_reg}
              - {level_reg[STATE_W-1], level_reg};

    // Operand selection for the shared multiplier.
    always_comb
    begin
        unique case (ctrl.mul_sel)
            MUL_C1R_DR:
            begin
                op_a = {coef.c1_real[DATA_W-1], coef.c1_real};
                op_b = dr_reg;
            end
            MUL_C1I_DI:
            begin
                op_a = {coef.c1_imag[DATA_W-1], coef.c1_imag};
                op_b = di_reg;
            end
            MUL_C1R_DI:
            begin
                op_a = {coef.c1_real[DATA_W-1], coef.c1_real};
                op_b = di_reg;
            end
            MUL_C1I_DR:
            begin
                op_a = {coef.c1_imag[DATA_W-1], coef.c1_imag};
                op_b = dr_reg;
            end
            MUL_C2R_ER:
            begin
                op_a = {coef.c2_real[DATA_W-1], coef.c2_real};
                op_b = er;
            end
            MUL_C2I_EI:
            begin
                op_a = {coef.c2_imag[DATA_W-1], coef.c2_imag};
                op_b = {inner_imag_reg[STATE_W-1], inner_imag_reg};
            end
            MUL_GAIN_LVL:
            begin
                op_a = {coef.gain[DATA_W-1], coef.gain};
                op_b = {level_reg[STATE_W-1], level_reg};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_next = op_a * op_b;
    assign prod_ext  = {prod_reg[PROD_W-1], prod_reg};

    // Accumulator works on the product registered in the previous cycle.
    always_comb
    begin
        unique case (ctrl.acc_op)
            ACC_LOAD: acc_next = prod_ext;
            ACC_ADD:  acc_next = acc_reg + prod_ext;
            ACC_SUB:  acc_next = acc_reg - prod_ext;
            default:  acc_next = acc_reg;
        endcase
    end

    // One shared add and clamp serves all three state updates.
    always_comb
    begin
        priority if (ctrl.wr_inner_real)
            upd_state = inner_real_reg;
        else if (ctrl.wr_inner_imag)
            upd_state = inner_imag_reg;
        else
            upd_state = level_reg;
    end

    assign upd_sum     = (acc_reg >>> COEF_FRAC)
                       + $signed({{(ACC_W-STATE_W){upd_state[STATE_W-1]}}, upd_state});
    assign upd_sat     = sat_word(upd_sum);
    assign out_shifted = prod_ext >>> GAIN_FRAC;
    assign out_sat     = sat_word(out_shifted);

    // State and step differences.
    always_comb
    begin
        inner_real_next = inner_real_reg;
        inner_imag_next = inner_imag_reg;
        level_next      = level_reg;
        dr_next         = dr_reg;
        di_next         = di_reg;
        clip_next       = clip_reg;
        if (ctrl.start_restart)
        begin
            inner_real_next = '0;
            inner_imag_next = '0;
            level_next      = coef.init_level;
            clip_next       = 1'b0;
        end
        if (ctrl.start_step)
        begin
            dr_next   = {sample_in[DATA_W-1], sample_in}
                      - {inner_real_reg[STATE_W-1], inner_real_reg};
            di_next   = '0 - {inner_imag_reg[STATE_W-1], inner_imag_reg};
            clip_next = 1'b0;
        end
        if (ctrl.wr_inner_real)
        begin
            inner_real_next = upd_sat.value;
            clip_next       = clip_reg | upd_sat.clip;
        end
        if (ctrl.wr_inner_imag)
        begin
            inner_imag_next = upd_sat.value;
            clip_next       = clip_reg | upd_sat.clip;
        end
        if (ctrl.wr_level)
        begin
            level_next = upd_sat.value;
            clip_next  = clip_reg | upd_sat.clip;
        end
    end

    // Filter state, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_real_reg <= '0;
            inner_imag_reg <= '0;
            level_reg      <= '0;
        end
        else
        begin
            inner_real_reg <= inner_real_next;
            inner_imag_reg <= inner_imag_next;
            level_reg      <= level_next;
        end
    end

    // Working registers and the output payload.
    always_ff @(posedge clk)
    begin
        dr_reg   <= dr_next;
        di_reg   <= di_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        clip_reg <= clip_next;
        if (ctrl.out_load)
        begin
            sample_out_reg <= out_sat.value;
            saturated_reg  <= clip_reg | out_sat.clip;
        end
    end

endmodule

>>> src/sopl_seq.sv
// Sequencer that steps the shared multiply-accumulate through one sample.
module sopl_seq
    import sopl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       op,
    input  logic       out_stall,
    output logic       in_stall,
    output logic       out_valid,
    output dp_ctrl_t   ctrl,
    output seq_state_t state
);

    seq_state_t state_reg;
    seq_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_busy;

    assign out_busy  = out_valid_reg && out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign state     = state_reg;

    // Next state.
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = op ? ST_GAIN : ST_M0;
                else
                    state_next = ST_IDLE;
            end
            ST_M0:   state_next = ST_M1;
            ST_M1:   state_next = ST_M2;
            ST_M2:   state_next = ST_M3;
            ST_M3:   state_next = ST_M4;
            ST_M4:   state_next = ST_M5;
            ST_M5:   state_next = ST_M6;
            ST_M6:   state_next = ST_M7;
            ST_M7:   state_next = ST_M8;
            ST_M8:   state_next = ST_GAIN;
            ST_GAIN: state_next = ST_OUT;
            ST_OUT:  state_next = out_busy ? ST_OUT : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath control for each step.
    always_comb
    begin
        ctrl = '{start_step: 1'b0, start_restart: 1'b0, mul_sel: MUL_NONE,
                 acc_op: ACC_HOLD, wr_inner_real: 1'b0, wr_inner_imag: 1'b0,
                 wr_level: 1'b0, out_load: 1'b0};
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.start_step    = in_valid && !op;
                ctrl.start_restart = in_valid && op;
            end
            ST_M0:
            begin
                ctrl.mul_sel = MUL_C1R_DR;
            end
            ST_M1:
            begin
                ctrl.mul_sel = MUL_C1I_DI;
                ctrl.acc_op  = ACC_LOAD;
            end
            ST_M2:
            begin
                ctrl.mul_sel = MUL_C1R_DI;
                ctrl.acc_op  = ACC_SUB;
            end
            ST_M3:
            begin
                ctrl.mul_sel       = MUL_C1I_DR;
                ctrl.acc_op        = ACC_LOAD;
                ctrl.wr_inner_real = 1'b1;
            end
            ST_M4:
            begin
                ctrl.acc_op = ACC_ADD;
            end
            ST_M5:
            begin
                ctrl.mul_sel       = MUL_C2R_ER;
                ctrl.wr_inner_imag = 1'b1;
            end
            ST_M6:
            begin
                ctrl.mul_sel = MUL_C2I_EI;
                ctrl.acc_op  = ACC_LOAD;
            end
            ST_M7:
            begin
                ctrl.acc_op = ACC_SUB;
            end
            ST_M8:
            begin
                ctrl.wr_level = 1'b1;
            end
            ST_GAIN:
            begin
                ctrl.mul_sel = MUL_GAIN_LVL;
            end
            ST_OUT:
            begin
                // Keep the gain product alive while the output is still occupied.
                ctrl.mul_sel  = MUL_GAIN_LVL;
                ctrl.out_load = !out_busy;
            end
            default:
            begin
                ctrl.out_load = 1'b0;
            end
        endcase
    end

    // Result valid: set on load, cleared when the result is taken.
    always_comb
    begin
        priority if (ctrl.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
